// ===== hw/rtl/four_wheel_cascade_motion_controller_defines.svh =====
// Assertion macros for the four-wheel cascade motion controller.
`ifndef FOUR_WHEEL_CASCADE_MOTION_CONTROLLER_DEFINES_SVH
`define FOUR_WHEEL_CASCADE_MOTION_CONTROLLER_DEFINES_SVH
`ifndef SYNTH
`define FWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FWC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FWC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FWC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hw/rtl/fwc_pkg.sv =====
// Types and constants shared by the motion controller modules.
`default_nettype none
package fwc_pkg;
    localparam int VW = 48;
    typedef logic signed [VW-1:0] val_t;
    localparam logic signed [VW-1:0] ONE_Q = 48'sd65536;
    localparam logic signed [VW-1:0] LIM48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VW-1:0] PWM_Q = 48'sd8399 * 48'sd65536;
    localparam logic signed [VW-1:0] INTEG_Q = 48'sd10000 * 48'sd65536;
    localparam logic signed [VW-1:0] MINP_Q = 48'sd300 * 48'sd65536;
    localparam logic signed [VW-1:0] DEC_Q = 48'sd100 * 48'sd65536;
    localparam logic signed [VW-1:0] ACC_Q = 48'sd50 * 48'sd65536;
    localparam logic signed [VW-1:0] PROF_WIN = 48'sd50000;
    localparam logic signed [VW-1:0] NEAR_WIN = 48'sd250;
    localparam logic signed [VW-1:0] HALF_TURN = 48'sd46080;
    localparam logic signed [VW-1:0] FULL_TURN = 48'sd92160;
    localparam logic signed [VW-1:0] TOL_Q8 = 48'sd256;
    localparam logic signed [17:0] K_FINE = 18'sd655;
    localparam logic signed [17:0] K_SPEED_I = 18'sd6554;
    localparam logic signed [17:0] K_HEAD_P = 18'sd200;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0, MODE_DIST = 3'd1, MODE_TURN = 3'd2,
        MODE_WDIST = 3'd3, MODE_HEAD = 3'd4, MODE_SPEED = 3'd5
    } mode_e;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0, REG_TPOS = 3'd1, REG_TANG = 3'd2,
        REG_WS0 = 3'd3, REG_WS1 = 3'd4, REG_WS2 = 3'd5, REG_WS3 = 3'd6
    } reg_e;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PROF, ST_POS, ST_POSM, ST_HEAD, ST_HEADM,
        ST_SPD, ST_SPDM, ST_DONE, ST_OUT
    } state_e;

    function automatic val_t sat48(input logic signed [VW+1:0] x);
        if (x > 50'(LIM48)) return LIM48;
        else if (x < -50'(LIM48) - 50'sd1) return -LIM48 - 48'sd1;
        else return x[VW-1:0];
    endfunction

    function automatic val_t clampv(input val_t x, input val_t lo, input val_t hi);
        if (x < lo) return lo;
        else if (x > hi) return hi;
        else return x;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/fwc_mul.sv =====
// Registered Q16 gain multiplier: product shifted right by 16, rounded down.
`default_nettype none
module fwc_mul
    import fwc_pkg::*;
(
    input  wire logic              clk,
    input  wire val_t              a,
    input  wire logic signed [17:0] k,
    output val_t                   p
);
    logic signed [65:0] prod;
    val_t p_reg;
    assign prod = a * k;
    always_ff @(posedge clk)
    begin
        p_reg <= prod[63:16];
    end
    assign p = p_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/four_wheel_cascade_motion_controller.sv =====
// Top level of the four-wheel cascade motion controller.
// Each request runs the profile step, its mode's loop steps, then done and output.
// One shared multiplier serves the loops; one request is handled at a time.
// The next request is taken once the result has been handed over.
// Reset clears the config registers, loop state and reached flags to zero.
`include "four_wheel_cascade_motion_controller_defines.svh"
`default_nettype none
module four_wheel_cascade_motion_controller
    import fwc_pkg::*;
#(
    parameter int WHEELS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // wheel[1:0], position[33:2], measured_speed[49:34], yaw[66:50], zero fill
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // drive[15:0], wheel_reached[16], all_reached[17], zero fill
    output logic [23:0]      m_tdata
);
    localparam int WB = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [2:0] mode_reg;
    logic signed [31:0] tpos_reg;
    logic signed [17:0] tang_reg;
    logic signed [14:0] ws_reg [4];

    val_t sle_reg [WHEELS], spe_reg [WHEELS], acc_reg [WHEELS], ple_reg [WHEELS];
    val_t hi_reg [WHEELS], hle_reg [WHEELS], prof_reg [WHEELS];
    logic [WHEELS-1:0] rf_reg;

    state_e st_reg, st_next;
    logic [1:0] w_reg;
    val_t pos_reg, meas_reg, yaw_reg, perr_reg;
    val_t t_reg, v_reg, eq_reg, dq_reg;
    logic [15:0] drv_reg;
    logic fl_reg, all_reg;

    val_t mul_a;
    logic signed [17:0] mul_k;
    val_t mul_p;
    fwc_mul u_mul (.clk(clk), .a(mul_a), .k(mul_k), .p(mul_p));

    logic [WB-1:0] wi;
    logic inr, left, near;
    val_t ts, tsq, aperr;
    assign inr = ({30'd0, w_reg} < 32'(WHEELS));
    assign wi = inr ? WB'(w_reg) : '0;
    assign left = {30'd0, w_reg} < 32'(WHEELS / 2);
    assign ts = 48'(ws_reg[w_reg]);
    assign tsq = ts <<< 16;
    assign aperr = perr_reg < 0 ? -perr_reg : perr_reg;
    assign near = aperr < NEAR_WIN;

    // heading error
    val_t e8, heq;
    always_comb
    begin
        if (48'(tang_reg) == HALF_TURN && yaw_reg < 0) e8 = -(48'(tang_reg) + yaw_reg);
        else e8 = 48'(tang_reg) - yaw_reg;
        heq = e8 <<< 8;
    end

    // turn error
    val_t te8, tact;
    logic treach;
    always_comb
    begin
        te8 = 48'(tang_reg) - yaw_reg;
        if (te8 > HALF_TURN) te8 = te8 - FULL_TURN;
        else if (te8 < -HALF_TURN) te8 = te8 + FULL_TURN;
        treach = (te8 < 0 ? -te8 : te8) < TOL_Q8;
        tact = ts;
        if (treach) tact = '0;
        else if ((ts > 0) != (te8 <= 0)) tact = -ts;
    end

    always_comb
    begin
        mul_a = eq_reg;
        mul_k = K_FINE;
        unique case (st_reg)
            ST_HEAD: begin mul_a = heq <<< 16; mul_k = K_HEAD_P; end
            ST_SPD:  begin mul_a = eq_reg; mul_k = K_SPEED_I; end
            default: begin mul_a = eq_reg; mul_k = K_FINE; end
        endcase
    end

    // profile next
    val_t prof_n;
    always_comb
    begin
        logic fwd;
        val_t cs;
        val_t dp;
        fwd = ts > 0;
        cs = prof_reg[wi];
        dp = pos_reg < 0 ? -pos_reg : pos_reg;
        if (aperr <= PROF_WIN) begin
            if (fwd) begin cs = cs - DEC_Q; if (cs <= MINP_Q) cs = MINP_Q; end
            else begin cs = cs + DEC_Q; if (cs >= -MINP_Q) cs = -MINP_Q; end
        end else if (dp <= PROF_WIN) begin
            if (fwd) begin cs = cs + ACC_Q; if (cs >= tsq) cs = tsq; end
            else begin cs = cs - ACC_Q; if (cs <= tsq) cs = tsq; end
        end else cs = tsq;
        prof_n = cs;
    end

    // position loop combine
    logic signed [VW+1:0] pd, pout, vcl;
    always_comb
    begin
        pd = 50'(eq_reg) - 50'(ple_reg[wi]);
        pout = 50'(near ? mul_p : eq_reg) + pd + (pd >>> 1);
        vcl = pout;
        if (vcl > 50'(t_reg)) vcl = 50'(t_reg);
        if (vcl < -50'(t_reg)) vcl = -50'(t_reg);
    end

    // heading loop combine
    val_t hint, hout;
    always_comb
    begin
        hint = clampv(hi_reg[wi] + eq_reg, -INTEG_Q, INTEG_Q);
        hout = -(mul_p + (hint >>> 1) + (eq_reg - hle_reg[wi]));
    end

    // speed loop combine
    val_t serr, sadd, sacc;
    always_comb
    begin
        serr = eq_reg;
        sadd = (serr - sle_reg[wi]) + mul_p
             + ((serr + spe_reg[wi] - (sle_reg[wi] <<< 1)) >>> 1);
        sacc = clampv(acc_reg[wi] + sadd, -PWM_Q, PWM_Q);
    end

    logic signed [VW-1:0] dtr;
    logic [15:0] drv_n;
    always_comb
    begin
        dtr = dq_reg / ONE_Q;
        if (dtr > 48'sd32767) drv_n = 16'h7FFF;
        else if (dtr < -48'sd32768) drv_n = 16'h8000;
        else drv_n = dtr[15:0];
    end

    logic allf;
    assign allf = &rf_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (s_tvalid) st_next = ST_PROF;
            ST_PROF:
                if (!inr) st_next = ST_DONE;
                else
                    case (mode_reg) inside
                        MODE_DIST, MODE_WDIST: st_next = ST_POS;
                        MODE_TURN, MODE_SPEED: st_next = ST_SPD;
                        MODE_HEAD: st_next = ST_HEAD;
                        default: st_next = ST_DONE;
                    endcase
            ST_POS:  st_next = ST_POSM;
            ST_POSM:
                if (mode_reg == MODE_DIST) st_next = ST_HEAD;
                else st_next = near ? ST_DONE : ST_SPD;
            ST_HEAD: st_next = ST_HEADM;
            ST_HEADM:
                if (mode_reg == MODE_HEAD || near) st_next = ST_DONE;
                else st_next = ST_SPD;
            ST_SPD:  st_next = ST_SPDM;
            ST_SPDM: st_next = ST_DONE;
            ST_DONE: st_next = ST_OUT;
            ST_OUT:  if (m_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            mode_reg <= '0; tpos_reg <= '0; tang_reg <= '0;
            for (int i = 0; i < 4; i++) ws_reg[i] <= '0;
            for (int i = 0; i < WHEELS; i++)
            begin
                sle_reg[i] <= '0; spe_reg[i] <= '0; acc_reg[i] <= '0;
                ple_reg[i] <= '0; hi_reg[i] <= '0; hle_reg[i] <= '0;
                prof_reg[i] <= '0;
            end
            rf_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
                case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[2:0];
                    REG_TPOS: tpos_reg <= cfg_data;
                    REG_TANG: tang_reg <= cfg_data[17:0];
                    REG_WS0:  ws_reg[0] <= cfg_data[14:0];
                    REG_WS1:  ws_reg[1] <= cfg_data[14:0];
                    REG_WS2:  ws_reg[2] <= cfg_data[14:0];
                    REG_WS3:  ws_reg[3] <= cfg_data[14:0];
                    default: ;
                endcase
            unique case (st_reg)
                ST_PROF:
                    if (inr && mode_reg == MODE_DIST) prof_reg[wi] <= sat48(50'(prof_n));
                ST_POSM:
                begin
                    ple_reg[wi] <= eq_reg;
                    if (mode_reg == MODE_WDIST) rf_reg[wi] <= near;
                end
                ST_HEADM:
                begin
                    hi_reg[wi] <= hint;
                    hle_reg[wi] <= eq_reg;
                    if (mode_reg == MODE_HEAD) rf_reg[wi] <= 1'b0;
                    else rf_reg[wi] <= near;
                end
                ST_SPD:
                    if (mode_reg == MODE_TURN) rf_reg[wi] <= treach;
                ST_SPDM:
                begin
                    acc_reg[wi] <= sacc;
                    spe_reg[wi] <= sle_reg[wi];
                    sle_reg[wi] <= serr;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                w_reg <= s_tdata[1:0];
                pos_reg <= 48'($signed(s_tdata[33:2]));
                meas_reg <= 48'($signed(s_tdata[49:34]));
                yaw_reg <= 48'($signed(s_tdata[66:50]));
                perr_reg <= 48'(tpos_reg) - 48'($signed(s_tdata[33:2]));
                dq_reg <= '0;
            end
            ST_PROF:
            begin
                t_reg <= sat48(50'(prof_n));
                if (mode_reg == MODE_HEAD) eq_reg <= heq;
                else if (mode_reg == MODE_SPEED)
                    eq_reg <= sat48(50'(tsq) - 50'(meas_reg <<< 16));
                else if (mode_reg == MODE_TURN)
                    eq_reg <= sat48(50'(left ? (tact <<< 16) : -(tact <<< 16))
                                    - 50'(meas_reg <<< 16));
                else eq_reg <= sat48(50'(perr_reg) <<< 16);
            end
            ST_POS: ;
            ST_POSM:
            begin
                v_reg <= vcl[VW-1:0];
                if (mode_reg == MODE_WDIST)
                    eq_reg <= sat48(50'(pout > 0 ? tsq : -tsq) - 50'(meas_reg <<< 16));
                else eq_reg <= heq;
            end
            ST_HEADM:
            begin
                if (mode_reg == MODE_HEAD) dq_reg <= left ? tsq + hout : tsq - hout;
                else
                    eq_reg <= sat48(50'(left ? v_reg + hout : v_reg - hout)
                                    - 50'(meas_reg <<< 16));
            end
            ST_SPDM: dq_reg <= sacc;
            ST_DONE:
            begin
                drv_reg <= drv_n;
                fl_reg <= inr ? rf_reg[wi] : 1'b0;
                if (mode_reg == MODE_DIST || mode_reg == MODE_WDIST)
                    all_reg <= allf && !(aperr > NEAR_WIN);
                else if (mode_reg == MODE_TURN) all_reg <= allf;
                else all_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata = {6'd0, all_reg, fl_reg, drv_reg};

    `FWC_ASSERT(a_excl, clk, rst_n, !(s_tready && m_tvalid), "ready while result pending")
    `FWC_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result dropped")
    `FWC_ASSERT_NEXT(a_go, clk, rst_n, s_tvalid && s_tready, !s_tready, "request not taken")
endmodule
`default_nettype wire
